[design/gntg_pkg.sv]
// Package for the grid normal and tangent generator.
// Holds item types, controller/datapath command structs, codes and shared functions.
// No dependencies.
package gntg_pkg;

	// Default parameter values.
	localparam int DEF_MAX_ROW_LENGTH = 64;
	localparam int DEF_MAX_ROW_COUNT  = 64;

	// Configuration port.
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 1'd1;
	localparam logic [CFG_W-1:0] RESET_ROW_LENGTH = 7'd64;
	localparam logic [CFG_W-1:0] RESET_ROW_COUNT  = 7'd64;

	// Arithmetic widths.
	localparam int COORD_W  = 24;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int PROD_W   = 2 * DIFF_W;
	localparam int ACC_W    = PROD_W + 1;
	localparam int OUT_W    = 32;
	localparam int INDEX_W  = 12;
	localparam int FRAC_W   = 16;
	localparam int SHIFT_W  = ACC_W + 1 - FRAC_W;
	localparam int ROUND_HALF = 32768;
	localparam int MUL_STEPS  = 7;
	localparam int NUM_COMP   = 3;
	localparam int DIV_ITER   = 33;
	localparam logic signed [OUT_W-1:0] SAT_POS = 32'sh7FFF_FFFF;
	localparam logic signed [OUT_W-1:0] SAT_NEG = 32'sh8000_0000;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic signed [COORD_W-1:0] tex_u;
		logic signed [COORD_W-1:0] tex_v;
	} in_item_t;

	typedef struct packed {
		logic [INDEX_W-1:0]      vertex_index;
		logic signed [OUT_W-1:0] normal_x;
		logic signed [OUT_W-1:0] normal_y;
		logic signed [OUT_W-1:0] normal_z;
		logic signed [OUT_W-1:0] tangent_x;
		logic signed [OUT_W-1:0] tangent_y;
		logic signed [OUT_W-1:0] tangent_z;
		logic                    degenerate;
		logic                    grid_done;
	} out_item_t;

	// Product pairs, each computed as a*b - c*d.
	typedef enum logic [2:0] {
		P_N0, P_N1, P_N2, P_DET, P_T0, P_T1, P_T2
	} pair_t;

	// Which neighbour set one result uses.
	typedef enum logic [1:0] {
		JOB_PREV, JOB_FIRST, JOB_OWN
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD_A, ST_RD_B, ST_LOAD, ST_DIFF, ST_MUL,
		ST_DIV_START, ST_DIV_WAIT, ST_EMIT, ST_WRITE
	} state_t;

	typedef struct packed {
		logic               load_cur;
		logic               rd_en;
		logic               latch_a;
		logic               latch_b;
		logic               diff_en;
		logic               mul_en;
		pair_t              mul_sel;
		logic               div_start;
		logic [1:0]         div_comp;
		logic               out_load;
		job_t               job;
		logic [INDEX_W-1:0] index;
		logic               grid_done;
		logic               wr_en;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic det_zero;
		logic out_free;
	} dp_sts_t;

	// Round a Q.32 cross product to nearest (ties up) in Q16.16 and saturate.
	function automatic logic signed [OUT_W-1:0] round_normal(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W:0]     biased;
		logic signed [SHIFT_W-1:0] shifted;
		biased  = (ACC_W+1)'(v) + (ACC_W+1)'(ROUND_HALF);
		shifted = SHIFT_W'(biased >>> FRAC_W);
		if ((&shifted[SHIFT_W-1:OUT_W-1]) || !(|shifted[SHIFT_W-1:OUT_W-1])) begin
			return shifted[OUT_W-1:0];
		end
		return shifted[SHIFT_W-1] ? SAT_NEG : SAT_POS;
	endfunction

endpackage

[design/gntg_if.sv]
// Valid/ready channel interfaces for input vertices and output results.
// Depends on gntg_pkg for the item types.
interface gntg_in_if import gntg_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gntg_out_if import gntg_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/gntg_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module gntg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

[design/gntg_divider.sv]
// Iterative restoring divider: num * 2^16 / den, rounded half away from zero, saturated.
// One quotient bit per cycle. Depends on gntg_pkg.
module gntg_divider import gntg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] num,
	input  logic signed [ACC_W-1:0] den,
	output logic                    done,
	output logic signed [OUT_W-1:0] quot
);
	localparam int DD_W  = ACC_W + FRAC_W;
	localparam int REM_W = DD_W + 1;
	localparam int CNT_W = $clog2(DIV_ITER);

	logic                busy_q, done_q, neg_q, sat_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [REM_W-1:0]    rem_q;
	logic [DD_W-1:0]     dd_q;
	logic [DIV_ITER-1:0] q_q;
	logic [ACC_W-1:0]    num_mag, den_mag;
	logic [DD_W-1:0]     den_sh;
	logic [REM_W-1:0]    rem_sh;
	logic                take;
	logic [DIV_ITER:0]   q_inc;
	logic [DIV_ITER-1:0] mag;

	// Operand magnitudes, the shifted divisor and the restoring subtract test.
	always_comb begin
		num_mag = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
		den_mag = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
		den_sh  = {den_mag, FRAC_W'(0)};
		rem_sh  = {rem_q[REM_W-2:0], 1'b0};
		take    = rem_sh >= REM_W'(dd_q);
	end

	// Control state of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (DD_W'(num_mag) >= den_sh) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_ITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[ACC_W-1] ^ den[ACC_W-1];
			sat_q <= DD_W'(num_mag) >= den_sh;
			dd_q  <= den_sh;
			rem_q <= REM_W'(num_mag);
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= take ? rem_sh - REM_W'(dd_q) : rem_sh;
			q_q   <= {q_q[DIV_ITER-2:0], take};
		end
	end

	// Round the extra fraction bit away and apply the sign with saturation.
	always_comb begin
		q_inc = (DIV_ITER+1)'(q_q) + 1'b1;
		mag   = q_inc[DIV_ITER:1];
		if (neg_q) begin
			if (sat_q || mag > DIV_ITER'(33'h0_8000_0000)) begin
				quot = SAT_NEG;
			end else begin
				quot = OUT_W'(-mag);
			end
		end else begin
			if (sat_q || mag >= DIV_ITER'(33'h0_8000_0000)) begin
				quot = SAT_POS;
			end else begin
				quot = mag[OUT_W-1:0];
			end
		end
	end

	assign done = done_q;
endmodule

[design/gntg_datapath.sv]
// Datapath: vertex window RAM, edge differences, shared product pair unit,
// divider and the output register. Depends on gntg_pkg, gntg_if, gntg_ram, gntg_divider.
module gntg_datapath import gntg_pkg::*; #(
	parameter int MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
	parameter int SLOT_W         = $clog2(MAX_ROW_LENGTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	input  logic [SLOT_W-1:0] rd_addr,
	input  logic [SLOT_W-1:0] wr_addr,
	input  in_item_t          in_data,
	output dp_sts_t           sts,
	gntg_out_if.source        out_ch
);
	in_item_t cur_q, va_q, vb_q, rd_data, v0, v1, v2;
	logic signed [DIFF_W-1:0] e0_q [3];
	logic signed [DIFF_W-1:0] e1_q [3];
	logic signed [DIFF_W-1:0] du0_q, dv0_q, du1_q, dv1_q;
	logic signed [DIFF_W-1:0] ma, mb, mc, md;
	logic signed [PROD_W-1:0] prod_a_s1, prod_b_s1;
	logic                     mul_vld_s1;
	pair_t                    sel_s1;
	logic signed [ACC_W-1:0]  pair_q [MUL_STEPS];
	logic signed [OUT_W-1:0]  tan_q [NUM_COMP];
	logic signed [ACC_W-1:0]  div_num;
	logic                     div_done;
	logic signed [OUT_W-1:0]  div_quot;
	logic                     det_zero;
	logic                     out_valid_q;
	out_item_t                out_q;

	// Vertex window, one entry per column slot.
	gntg_ram #(
		.WIDTH($bits(in_item_t)),
		.DEPTH(MAX_ROW_LENGTH)
	) u_window (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(wr_addr),
		.wr_data(cur_q),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Arrange the three vertices for the current result.
	always_comb begin
		if (cmd.job == JOB_OWN) begin
			v0 = cur_q;
			v1 = va_q;
			v2 = vb_q;
		end else begin
			v0 = va_q;
			v1 = vb_q;
			v2 = cur_q;
		end
	end

	// Operand selection for the product pair unit.
	always_comb begin
		case (cmd.mul_sel)
			P_N0: begin ma = e1_q[1]; mb = e0_q[2]; mc = e1_q[2]; md = e0_q[1]; end
			P_N1: begin ma = e1_q[2]; mb = e0_q[0]; mc = e1_q[0]; md = e0_q[2]; end
			P_N2: begin ma = e1_q[0]; mb = e0_q[1]; mc = e1_q[1]; md = e0_q[0]; end
			P_DET: begin ma = du0_q; mb = dv1_q; mc = dv0_q; md = du1_q; end
			P_T0: begin ma = e0_q[0]; mb = dv1_q; mc = e1_q[0]; md = dv0_q; end
			P_T1: begin ma = e0_q[1]; mb = dv1_q; mc = e1_q[1]; md = dv0_q; end
			P_T2: begin ma = e0_q[2]; mb = dv1_q; mc = e1_q[2]; md = dv0_q; end
			default: begin ma = '0; mb = '0; mc = '0; md = '0; end
		endcase
	end

	// Vertex latches, edge differences, products and pair differences.
	always_ff @(posedge clk) begin
		if (cmd.load_cur) begin
			cur_q <= in_data;
		end
		if (cmd.latch_a) begin
			va_q <= rd_data;
		end
		if (cmd.latch_b) begin
			vb_q <= rd_data;
		end
		if (cmd.diff_en) begin
			e0_q[0] <= DIFF_W'(v1.pos_x) - DIFF_W'(v0.pos_x);
			e0_q[1] <= DIFF_W'(v1.pos_y) - DIFF_W'(v0.pos_y);
			e0_q[2] <= DIFF_W'(v1.pos_z) - DIFF_W'(v0.pos_z);
			e1_q[0] <= DIFF_W'(v2.pos_x) - DIFF_W'(v0.pos_x);
			e1_q[1] <= DIFF_W'(v2.pos_y) - DIFF_W'(v0.pos_y);
			e1_q[2] <= DIFF_W'(v2.pos_z) - DIFF_W'(v0.pos_z);
			du0_q   <= DIFF_W'(v1.tex_u) - DIFF_W'(v0.tex_u);
			dv0_q   <= DIFF_W'(v1.tex_v) - DIFF_W'(v0.tex_v);
			du1_q   <= DIFF_W'(v2.tex_u) - DIFF_W'(v0.tex_u);
			dv1_q   <= DIFF_W'(v2.tex_v) - DIFF_W'(v0.tex_v);
		end
		prod_a_s1 <= ma * mb;
		prod_b_s1 <= mc * md;
		sel_s1    <= cmd.mul_sel;
		if (mul_vld_s1) begin
			pair_q[sel_s1] <= ACC_W'(prod_a_s1) - ACC_W'(prod_b_s1);
		end
		if (div_done) begin
			tan_q[cmd.div_comp] <= div_quot;
		end
	end

	// Product stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_vld_s1 <= 1'b0;
		end else begin
			mul_vld_s1 <= cmd.mul_en;
		end
	end

	// Numerator for the tangent component under division.
	always_comb begin
		case (cmd.div_comp)
			2'd0: div_num = pair_q[P_T0];
			2'd1: div_num = pair_q[P_T1];
			2'd2: div_num = pair_q[P_T2];
			default: div_num = '0;
		endcase
	end

	gntg_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (pair_q[P_DET]),
		.done  (div_done),
		.quot  (div_quot)
	);

	assign det_zero = pair_q[P_DET] == '0;

	// Output register; it holds a result until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.vertex_index <= cmd.index;
			out_q.normal_x     <= round_normal(pair_q[P_N0]);
			out_q.normal_y     <= round_normal(pair_q[P_N1]);
			out_q.normal_z     <= round_normal(pair_q[P_N2]);
			out_q.tangent_x    <= det_zero ? '0 : tan_q[0];
			out_q.tangent_y    <= det_zero ? '0 : tan_q[1];
			out_q.tangent_z    <= det_zero ? '0 : tan_q[2];
			out_q.degenerate   <= det_zero;
			out_q.grid_done    <= cmd.grid_done;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	assign sts.div_done = div_done;
	assign sts.det_zero = det_zero;
	assign sts.out_free = !out_valid_q || out_ch.ready;
endmodule

[design/gntg_ctrl.sv]
// Controller: configuration registers, vertex counter, window slot and the
// sequencer that drives the datapath. Depends on gntg_pkg.
module gntg_ctrl import gntg_pkg::*; #(
	parameter int MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
	parameter int MAX_ROW_COUNT  = DEF_MAX_ROW_COUNT,
	parameter int SLOT_W         = $clog2(MAX_ROW_LENGTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	output dp_cmd_t              cmd,
	input  dp_sts_t              sts,
	output logic [SLOT_W-1:0]    rd_addr,
	output logic [SLOT_W-1:0]    wr_addr
);
	localparam int LEN_W  = $clog2(MAX_ROW_LENGTH + 1);
	localparam int ROWS_W = $clog2(MAX_ROW_COUNT + 1);
	localparam int GRID_W = $clog2(MAX_ROW_LENGTH * MAX_ROW_COUNT + 1);
	localparam int CNT_W  = $clog2(MAX_ROW_LENGTH * MAX_ROW_COUNT);
	localparam int AW     = ((SLOT_W > LEN_W) ? SLOT_W : LEN_W) + 1;

	state_t              state_q, state_d;
	logic [CFG_W-1:0]    row_length_q, row_count_q;
	logic [CNT_W-1:0]    n_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                pend_prev_q, pend_first_q, pend_own_q, last_q;
	logic [2:0]          step_q;
	logic [1:0]          comp_q;
	logic [LEN_W-1:0]    len_l;
	logic [ROWS_W-1:0]   len_r;
	logic [GRID_W-1:0]   grid_len, last_start, nn, idx;
	logic                has_prev, has_first, has_own, is_last, more;
	job_t                job;
	logic [SLOT_W-1:0]   addr_a, addr_b;
	logic [GRID_W+INDEX_W-1:0] idx_ext;

	// Slot of the vertex that lies off places before the current one.
	function automatic logic [SLOT_W-1:0] back_slot(input logic [SLOT_W-1:0] base,
			input logic [LEN_W-1:0] off);
		logic [AW-1:0] b;
		logic [AW-1:0] o;
		b = AW'(base);
		o = AW'(off);
		if (b >= o) begin
			return SLOT_W'(b - o);
		end
		return SLOT_W'(b + AW'(MAX_ROW_LENGTH) - o);
	endfunction

	// Clamped grid geometry and the neighbour cases of the current vertex.
	always_comb begin
		if (row_length_q < CFG_W'(3)) begin
			len_l = LEN_W'(3);
		end else if (32'(row_length_q) > MAX_ROW_LENGTH) begin
			len_l = LEN_W'(MAX_ROW_LENGTH);
		end else begin
			len_l = LEN_W'(row_length_q);
		end
		if (row_count_q < CFG_W'(2)) begin
			len_r = ROWS_W'(2);
		end else if (32'(row_count_q) > MAX_ROW_COUNT) begin
			len_r = ROWS_W'(MAX_ROW_COUNT);
		end else begin
			len_r = ROWS_W'(row_count_q);
		end
		grid_len   = GRID_W'(len_l) * GRID_W'(len_r);
		last_start = grid_len - GRID_W'(len_l);
		nn         = GRID_W'(n_q);
		has_prev   = nn >= GRID_W'(len_l);
		has_own    = nn >= last_start + 1'b1;
		has_first  = nn == last_start + GRID_W'(2);
		is_last    = nn == grid_len - 1'b1;
	end

	// Current job, its read addresses and its result index.
	always_comb begin
		if (pend_prev_q) begin
			job = JOB_PREV;
		end else if (pend_first_q) begin
			job = JOB_FIRST;
		end else begin
			job = JOB_OWN;
		end
		case (job)
			JOB_PREV: begin
				addr_a = back_slot(slot_q, len_l);
				addr_b = back_slot(slot_q, len_l - 1'b1);
				idx    = nn - GRID_W'(len_l);
			end
			JOB_FIRST: begin
				addr_a = back_slot(slot_q, LEN_W'(2));
				addr_b = back_slot(slot_q, LEN_W'(1));
				idx    = last_start;
			end
			default: begin
				addr_a = back_slot(slot_q, LEN_W'(1));
				addr_b = back_slot(slot_q, len_l);
				idx    = nn;
			end
		endcase
		idx_ext = {INDEX_W'(0), idx};
		case (job)
			JOB_PREV: more = pend_first_q || pend_own_q;
			JOB_FIRST: more = pend_own_q;
			default: more = 1'b0;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (has_prev || has_own) ? ST_RD_A : ST_WRITE;
				end
			end
			ST_RD_A: state_d = ST_RD_B;
			ST_RD_B: state_d = ST_LOAD;
			ST_LOAD: state_d = ST_DIFF;
			ST_DIFF: state_d = ST_MUL;
			ST_MUL: begin
				if (step_q == 3'(MUL_STEPS)) begin
					state_d = ST_DIV_START;
				end
			end
			ST_DIV_START: state_d = sts.det_zero ? ST_EMIT : ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					state_d = (comp_q == 2'(NUM_COMP - 1)) ? ST_EMIT : ST_DIV_START;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					state_d = more ? ST_RD_A : ST_WRITE;
				end
			end
			ST_WRITE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath commands.
	always_comb begin
		cmd           = '0;
		cmd.job       = job;
		cmd.index     = idx_ext[INDEX_W-1:0];
		cmd.grid_done = (job == JOB_OWN) && last_q;
		cmd.div_comp  = comp_q;
		cmd.mul_sel   = pair_t'(step_q);
		in_ready      = 1'b0;
		rd_addr       = addr_a;
		case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_cur = in_valid;
			end
			ST_RD_A: cmd.rd_en = 1'b1;
			ST_RD_B: begin
				cmd.rd_en   = 1'b1;
				cmd.latch_a = 1'b1;
				rd_addr     = addr_b;
			end
			ST_LOAD: cmd.latch_b = 1'b1;
			ST_DIFF: cmd.diff_en = 1'b1;
			ST_MUL: cmd.mul_en = step_q < 3'(MUL_STEPS);
			ST_DIV_START: cmd.div_start = !sts.det_zero;
			ST_EMIT: cmd.out_load = sts.out_free;
			ST_WRITE: cmd.wr_en = 1'b1;
			default: ;
		endcase
	end

	assign wr_addr = slot_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			row_length_q <= RESET_ROW_LENGTH;
			row_count_q  <= RESET_ROW_COUNT;
			n_q          <= '0;
			slot_q       <= '0;
			pend_prev_q  <= 1'b0;
			pend_first_q <= 1'b0;
			pend_own_q   <= 1'b0;
			last_q       <= 1'b0;
			step_q       <= '0;
			comp_q       <= '0;
		end else begin
			state_q <= state_d;
			// A configuration write restarts the grid.
			if (cfg_write_en) begin
				if (cfg_index == CFG_ROW_LENGTH) begin
					row_length_q <= cfg_data;
					n_q          <= '0;
					slot_q       <= '0;
				end else if (cfg_index == CFG_ROW_COUNT) begin
					row_count_q <= cfg_data;
					n_q         <= '0;
					slot_q      <= '0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pend_prev_q  <= has_prev;
						pend_first_q <= has_first;
						pend_own_q   <= has_own;
						last_q       <= is_last;
					end
				end
				ST_DIFF: step_q <= '0;
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					comp_q <= '0;
				end
				ST_DIV_WAIT: begin
					if (sts.div_done) begin
						comp_q <= comp_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						case (job)
							JOB_PREV: pend_prev_q <= 1'b0;
							JOB_FIRST: pend_first_q <= 1'b0;
							default: pend_own_q <= 1'b0;
						endcase
					end
				end
				ST_WRITE: begin
					if (last_q) begin
						n_q    <= '0;
						slot_q <= '0;
					end else begin
						n_q    <= n_q + 1'b1;
						slot_q <= (slot_q == SLOT_W'(MAX_ROW_LENGTH - 1)) ? '0 : slot_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

[design/grid_normal_tangent_generator_top.sv]
// Channel    | Dir | Payload                                   | Handshake
// in_ch      | in  | pos_x, pos_y, pos_z, tex_u, tex_v         | valid/ready
// out_ch     | out | vertex_index, normal, tangent, flags      | valid/ready
// cfg        | in  | cfg_index, cfg_data                       | cfg_write_en
//
// One vertex at a time: a vertex with no result passes through ST_IDLE and ST_WRITE;
// each result adds the read, load, difference, product and emit states plus one
// divider run per tangent component (one quotient bit per cycle); up to 3 results.
// A zero determinant skips the divider; an out-of-range quotient ends it without iterating.
// Reset (arst_n low) clears the controller; the window RAM is not cleared.
// A stalled output holds its result while the next vertex is already accepted.
// Top level; depends on gntg_pkg, gntg_if, gntg_ctrl and gntg_datapath.
module grid_normal_tangent_generator_top import gntg_pkg::*; #(
	parameter int MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
	parameter int MAX_ROW_COUNT  = DEF_MAX_ROW_COUNT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	gntg_in_if.sink              in_ch,
	gntg_out_if.source           out_ch
);
	localparam int SLOT_W = $clog2(MAX_ROW_LENGTH);

	dp_cmd_t           cmd;
	dp_sts_t           sts;
	logic [SLOT_W-1:0] rd_addr, wr_addr;
	logic              in_ready;

	// Sequencer and grid bookkeeping.
	gntg_ctrl #(
		.MAX_ROW_LENGTH(MAX_ROW_LENGTH),
		.MAX_ROW_COUNT (MAX_ROW_COUNT),
		.SLOT_W        (SLOT_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.sts         (sts),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr)
	);

	// Arithmetic, window storage and output register.
	gntg_datapath #(
		.MAX_ROW_LENGTH(MAX_ROW_LENGTH),
		.SLOT_W        (SLOT_W)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.in_data(in_ch.data),
		.sts    (sts),
		.out_ch (out_ch)
	);

	assign in_ch.ready = in_ready;
endmodule

[design/gntg_checker.sv]
// Port-level checker for the grid normal and tangent generator, bound to the top level.
// Depends on gntg_pkg.
module gntg_checker import gntg_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);
	// A result that is offered stays offered until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped before the transaction");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("output payload changed while stalled");

	// The block works on one vertex at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accepted transaction");

	// A degenerate result carries a zero tangent.
	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |->
		(out_data.tangent_x == '0 && out_data.tangent_y == '0 && out_data.tangent_z == '0))
		else $error("degenerate result with a nonzero tangent");
endmodule

bind grid_normal_tangent_generator_top gntg_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_data (out_ch.data)
);
